>>> hdl/sbldc_pkg.sv
package sbldc_pkg;

  typedef enum logic [1:0] {
    EDGE_EITHER  = 2'd0,
    EDGE_RISING  = 2'd1,
    EDGE_FALLING = 2'd2
  } edge_mode_e;

  typedef enum logic [1:0] {
    CFG_MIN_DUTY  = 2'd0,
    CFG_MAX_DUTY  = 2'd1,
    CFG_QUALIFY   = 2'd2,
    CFG_INIT_DUTY = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_BUTTON = 1'b1
  } req_type_e;

  localparam logic [1:0] PHASE_A    = 2'd0;
  localparam logic [1:0] PHASE_B    = 2'd1;
  localparam logic [1:0] PHASE_C    = 2'd2;
  localparam logic [1:0] PHASE_NONE = 2'd3;

  localparam logic [7:0] MIN_DUTY_RST  = 8'd50;
  localparam logic [7:0] MAX_DUTY_RST  = 8'd255;
  localparam logic [3:0] QUALIFY_RST   = 4'd10;
  localparam logic [7:0] INIT_DUTY_RST = 8'd100;
  localparam logic [3:0] MATCH_MAX     = 4'd15;
  localparam logic [2:0] LAST_STEP     = 3'd5;

  typedef struct packed {
    logic req_type;
    logic cmp_a;
    logic cmp_b;
    logic cmp_c;
    logic button_up;
    logic button_down;
  } in_word_t;

  typedef struct packed {
    logic [1:0] high_phase;
    logic [1:0] low_phase;
    logic [7:0] pwm_duty;
    logic [2:0] pending_step;
    logic       commutated;
    logic [1:0] sensed_phase;
  } out_word_t;

  // per step: drive pair, then sense phase and edge armed next
  typedef struct packed {
    logic [1:0] high_phase;
    logic [1:0] low_phase;
    logic [1:0] sense;
    edge_mode_e edge_mode;
  } step_entry_t;

  function automatic step_entry_t step_entry(input logic [2:0] step);
    step_entry_t e;
    case (step)
      3'd0:    e = '{PHASE_A, PHASE_B, PHASE_C, EDGE_RISING};
      3'd1:    e = '{PHASE_A, PHASE_C, PHASE_B, EDGE_FALLING};
      3'd2:    e = '{PHASE_B, PHASE_C, PHASE_A, EDGE_RISING};
      3'd3:    e = '{PHASE_B, PHASE_A, PHASE_C, EDGE_FALLING};
      3'd4:    e = '{PHASE_C, PHASE_A, PHASE_B, EDGE_RISING};
      3'd5:    e = '{PHASE_C, PHASE_B, PHASE_A, EDGE_FALLING};
      default: e = '{PHASE_A, PHASE_B, PHASE_C, EDGE_RISING};
    endcase
    return e;
  endfunction

  function automatic logic pick_bit(input in_word_t w, input logic [1:0] phase);
    logic b;
    case (phase)
      PHASE_A: b = w.cmp_a;
      PHASE_B: b = w.cmp_b;
      default: b = w.cmp_c;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/sensorless_bldc_six_step_commutator.sv
// six-step sensorless bldc commutator
// input channel (in_valid_i / in_stall_o / in_word_i): one word per comparator
//   sample tick or speed button poll; every word gives exactly one result word
// output channel (out_valid_o / out_stall_i / out_word_o): drive pair, duty,
//   pending step, commutation flag and sensed phase after that word
// config port (cfg_we_i / cfg_idx_i / cfg_data_i): duty limits and qualify
//   count, which the user must write only while the block is idle (unenforced);
//   initial duty writes are ignored, so duty always starts at 100 after reset
// path from acceptance to a valid result: input register, then state update
//   and result register in one pass
// throughput: one word per cycle unless stalled; state update is the only loop
// stall: a held result is kept in the output register while the input
//   register can still take one more word; in_stall_o rises only when both
//   are full and the receiver stalls
// reset: drives off (phase none), step 0, phase A armed for either edge,
//   duty 100, pipeline empty
module sensorless_bldc_six_step_commutator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sbldc_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sbldc_pkg::out_word_t out_word_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  // config registers
  logic [7:0] min_duty_q, max_duty_q;
  logic [3:0] qualify_q;

  // pipeline
  logic                 s1_valid_q;
  sbldc_pkg::in_word_t  s1_word_q;
  logic                 out_valid_q;
  sbldc_pkg::out_word_t out_q, out_d;
  logic                 out_free, s1_fire, in_fire;

  // commutator state
  logic [2:0]            step_q, step_d;
  logic [7:0]            duty_q, duty_d;
  logic [1:0]            sense_q, sense_d;
  sbldc_pkg::edge_mode_e edge_q, edge_d;
  logic [3:0]            match_q, match_d;
  logic                  qual_q, qual_d;
  logic                  last_q, last_d;
  logic                  drive_q, drive_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_duty_q <= sbldc_pkg::MIN_DUTY_RST;
      max_duty_q <= sbldc_pkg::MAX_DUTY_RST;
      qualify_q  <= sbldc_pkg::QUALIFY_RST;
    end else if (cfg_we_i) begin
      case (sbldc_pkg::cfg_idx_e'(cfg_idx_i))
        sbldc_pkg::CFG_MIN_DUTY: min_duty_q <= cfg_data_i;
        sbldc_pkg::CFG_MAX_DUTY: max_duty_q <= cfg_data_i;
        sbldc_pkg::CFG_QUALIFY:  qualify_q  <= cfg_data_i[3:0];
        default: ; // initial duty only matters at reset
      endcase
    end
  end

  // per-word state update
  always_comb begin
    sbldc_pkg::step_entry_t cur, prev;
    logic       bit_s;
    logic       expect_s;
    logic [3:0] need;
    logic [3:0] match_inc;
    logic       rise, fall, hit;
    logic [2:0] prev_step;

    step_d  = step_q;
    duty_d  = duty_q;
    sense_d = sense_q;
    edge_d  = edge_q;
    match_d = match_q;
    qual_d  = qual_q;
    last_d  = last_q;
    drive_d = drive_q;
    out_d.commutated = 1'b0;

    cur       = sbldc_pkg::step_entry(step_q);
    bit_s     = sbldc_pkg::pick_bit(s1_word_q, sense_q);
    expect_s  = step_q[0];
    need      = (qualify_q == 4'd0) ? 4'd1 : qualify_q;
    match_inc = ((bit_s == expect_s) && (match_q < sbldc_pkg::MATCH_MAX)) ?
                match_q + 4'd1 : match_q;
    rise      = !last_q && bit_s;
    fall      = last_q && !bit_s;
    case (edge_q)
      sbldc_pkg::EDGE_RISING:  hit = rise;
      sbldc_pkg::EDGE_FALLING: hit = fall;
      default:                 hit = rise || fall;
    endcase

    if (s1_word_q.req_type == sbldc_pkg::REQ_BUTTON) begin
      // up first, then down against the updated duty
      if (s1_word_q.button_up && (duty_q < max_duty_q)) begin
        duty_d = duty_q + 8'd1;
      end
      if (s1_word_q.button_down && (duty_d > min_duty_q)) begin
        duty_d = duty_d - 8'd1;
      end
    end else begin
      last_d = bit_s;
      if (qual_q) begin
        match_d = match_inc;
        if (match_inc >= need) begin
          // qualified crossing: apply pending step and arm the next phase
          sense_d = cur.sense;
          edge_d  = cur.edge_mode;
          drive_d = 1'b1;
          step_d  = (step_q == sbldc_pkg::LAST_STEP) ? 3'd0 : step_q + 3'd1;
          qual_d  = 1'b0;
          match_d = 4'd0;
          out_d.commutated = 1'b1;
          last_d  = sbldc_pkg::pick_bit(s1_word_q, cur.sense);
        end
      end else if (hit) begin
        qual_d  = 1'b1;
        match_d = 4'd0;
      end
    end

    // drive pair of the most recently applied step
    prev_step = (step_d == 3'd0) ? sbldc_pkg::LAST_STEP : step_d - 3'd1;
    prev      = sbldc_pkg::step_entry(prev_step);
    out_d.high_phase   = drive_d ? prev.high_phase : sbldc_pkg::PHASE_NONE;
    out_d.low_phase    = drive_d ? prev.low_phase  : sbldc_pkg::PHASE_NONE;
    out_d.pwm_duty     = duty_d;
    out_d.pending_step = step_d;
    out_d.sensed_phase = sense_d;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= 3'd0;
      duty_q      <= sbldc_pkg::INIT_DUTY_RST;
      sense_q     <= sbldc_pkg::PHASE_A;
      edge_q      <= sbldc_pkg::EDGE_EITHER;
      match_q     <= 4'd0;
      qual_q      <= 1'b0;
      last_q      <= 1'b0;
      drive_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        step_q  <= step_d;
        duty_q  <= duty_d;
        sense_q <= sense_d;
        edge_q  <= edge_d;
        match_q <= match_d;
        qual_q  <= qual_d;
        last_q  <= last_d;
        drive_q <= drive_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_word_i;
    end
    if (s1_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_count_only_when_qualifying : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (match_q != 4'd0) |-> qual_q
  ) else $error("match count nonzero while not qualifying");

  a_step_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni) step_q <= sbldc_pkg::LAST_STEP
  ) else $error("pending step out of range");

  a_commutation_drives : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_q.commutated) |->
      (out_q.high_phase != sbldc_pkg::PHASE_NONE &&
       out_q.low_phase != sbldc_pkg::PHASE_NONE)
  ) else $error("commutation reported with drives off");

  a_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> (s1_valid_q && out_valid_q)
  ) else $error("input stalled with free pipeline slot");
`endif

endmodule

>>> test/commutator_checker.sv
module commutator_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  sbldc_pkg::in_word_t  in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  sbldc_pkg::out_word_t out_word_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  output int                   mismatches_o,
  output int                   waiting_o,
  output int                   checked_o,
  output int                   commutations_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // drive pair of each applied step and the phase watched after it
  localparam logic [1:0] HIGH_OF [6] = '{sbldc_pkg::PHASE_A, sbldc_pkg::PHASE_A,
                                         sbldc_pkg::PHASE_B, sbldc_pkg::PHASE_B,
                                         sbldc_pkg::PHASE_C, sbldc_pkg::PHASE_C};
  localparam logic [1:0] LOW_OF [6] = '{sbldc_pkg::PHASE_B, sbldc_pkg::PHASE_C,
                                        sbldc_pkg::PHASE_C, sbldc_pkg::PHASE_A,
                                        sbldc_pkg::PHASE_A, sbldc_pkg::PHASE_B};
  localparam logic [1:0] SENSE_OF [6] = '{sbldc_pkg::PHASE_C, sbldc_pkg::PHASE_B,
                                          sbldc_pkg::PHASE_A, sbldc_pkg::PHASE_C,
                                          sbldc_pkg::PHASE_B, sbldc_pkg::PHASE_A};

  logic [7:0] duty_floor, duty_ceiling;
  logic [3:0] qualify_need;

  logic [2:0]            step_q;
  logic [7:0]            duty_q;
  logic [1:0]            sense_q;
  sbldc_pkg::edge_mode_e edge_q;
  logic [3:0]            match_q;
  logic                  qualifying_q;
  logic                  last_bit_q;
  logic                  drives_on_q;

  sbldc_pkg::out_word_t expected_words [$];
  sbldc_pkg::out_word_t predicted;
  sbldc_pkg::out_word_t oldest;
  int                   mismatches;
  int                   checked;
  int                   commutations;

  function automatic logic floating_bit(input sbldc_pkg::in_word_t w,
                                        input logic [1:0] phase);
    logic b;
    case (phase)
      sbldc_pkg::PHASE_A: b = w.cmp_a;
      sbldc_pkg::PHASE_B: b = w.cmp_b;
      default:            b = w.cmp_c;
    endcase
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic predict_commutation(input sbldc_pkg::in_word_t w,
                                     output sbldc_pkg::out_word_t r);
    logic       b;
    logic       rise;
    logic       fall;
    logic       hit;
    logic       fired;
    logic [3:0] need;
    logic [2:0] applied;
    fired = 1'b0;
    if (w.req_type == sbldc_pkg::REQ_BUTTON) begin
      if (w.button_up && duty_q < duty_ceiling) duty_q = duty_q + 8'd1;
      if (w.button_down && duty_q > duty_floor) duty_q = duty_q - 8'd1;
    end else begin
      b = floating_bit(w, sense_q);
      if (qualifying_q) begin
        need = (qualify_need == 4'd0) ? 4'd1 : qualify_need;
        // odd pending step wants the floating phase high, even wants it low
        if (b == step_q[0] && match_q < sbldc_pkg::MATCH_MAX) match_q = match_q + 4'd1;
        if (match_q >= need) begin
          sense_q = SENSE_OF[step_q];
          edge_q = step_q[0] ? sbldc_pkg::EDGE_FALLING : sbldc_pkg::EDGE_RISING;
          drives_on_q = 1'b1;
          step_q = (step_q == sbldc_pkg::LAST_STEP) ? 3'd0 : step_q + 3'd1;
          qualifying_q = 1'b0;
          match_q = 4'd0;
          fired = 1'b1;
          b = floating_bit(w, sense_q);
        end
      end else begin
        rise = !last_bit_q && b;
        fall = last_bit_q && !b;
        case (edge_q)
          sbldc_pkg::EDGE_RISING:  hit = rise;
          sbldc_pkg::EDGE_FALLING: hit = fall;
          default:                 hit = rise || fall;
        endcase
        if (hit) begin
          qualifying_q = 1'b1;
          match_q = 4'd0;
        end
      end
      last_bit_q = b;
    end
    if (drives_on_q) begin
      applied = (step_q == 3'd0) ? sbldc_pkg::LAST_STEP : step_q - 3'd1;
      r.high_phase = HIGH_OF[applied];
      r.low_phase = LOW_OF[applied];
    end else begin
      r.high_phase = sbldc_pkg::PHASE_NONE;
      r.low_phase = sbldc_pkg::PHASE_NONE;
    end
    r.pwm_duty = duty_q;
    r.pending_step = step_q;
    r.commutated = fired;
    r.sensed_phase = sense_q;
    if (fired) commutations++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_floor = sbldc_pkg::MIN_DUTY_RST;
      duty_ceiling = sbldc_pkg::MAX_DUTY_RST;
      qualify_need = sbldc_pkg::QUALIFY_RST;
      step_q = 3'd0;
      duty_q = sbldc_pkg::INIT_DUTY_RST;
      sense_q = sbldc_pkg::PHASE_A;
      edge_q = sbldc_pkg::EDGE_EITHER;
      match_q = 4'd0;
      qualifying_q = 1'b0;
      last_bit_q = 1'b0;
      drives_on_q = 1'b0;
      expected_words.delete();
      mismatches_o <= 0;
      waiting_o <= 0;
      checked_o <= 0;
      commutations_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sbldc_pkg::CFG_MIN_DUTY:  duty_floor = cfg_data_i;
          sbldc_pkg::CFG_MAX_DUTY:  duty_ceiling = cfg_data_i;
          sbldc_pkg::CFG_QUALIFY:   qualify_need = cfg_data_i[3:0];
          // only read at reset, so the running duty is untouched
          sbldc_pkg::CFG_INIT_DUTY: ;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing outstanding", out_word_i));
        end else begin
          oldest = expected_words.pop_front();
          if (out_word_i.high_phase !== oldest.high_phase)
            report_mismatch($sformatf("word %0d high_phase %0d, want %0d", checked,
                                      out_word_i.high_phase, oldest.high_phase));
          if (out_word_i.low_phase !== oldest.low_phase)
            report_mismatch($sformatf("word %0d low_phase %0d, want %0d", checked,
                                      out_word_i.low_phase, oldest.low_phase));
          if (out_word_i.pwm_duty !== oldest.pwm_duty)
            report_mismatch($sformatf("word %0d pwm_duty %0d, want %0d", checked,
                                      out_word_i.pwm_duty, oldest.pwm_duty));
          if (out_word_i.pending_step !== oldest.pending_step)
            report_mismatch($sformatf("word %0d pending_step %0d, want %0d", checked,
                                      out_word_i.pending_step, oldest.pending_step));
          if (out_word_i.commutated !== oldest.commutated)
            report_mismatch($sformatf("word %0d commutated %0d, want %0d", checked,
                                      out_word_i.commutated, oldest.commutated));
          if (out_word_i.sensed_phase !== oldest.sensed_phase)
            report_mismatch($sformatf("word %0d sensed_phase %0d, want %0d", checked,
                                      out_word_i.sensed_phase, oldest.sensed_phase));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_commutation(in_word_i, predicted);
        expected_words.push_back(predicted);
      end
      mismatches_o <= mismatches;
      waiting_o <= expected_words.size();
      checked_o <= checked;
      commutations_o <= commutations;
    end
  end

endmodule

>>> test/tb_sensorless_bldc_six_step_commutator.sv
module tb_sensorless_bldc_six_step_commutator;
  timeunit 1ns;
  timeprecision 1ps;

  // register settings visited after the opening words; one of them sweeps the duty
  localparam int SETTINGS_RUN = 6;
  localparam int SWEEP_SETTING = 4;
  localparam int WORDS_PER_SETTING = 250;
  localparam int SWEEP_PRESSES = 260;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sbldc_pkg::in_word_t  in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sbldc_pkg::out_word_t out_word;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_idx = sbldc_pkg::CFG_MIN_DUTY;
  logic [7:0]           cfg_data = '0;

  int mismatches;
  int waiting;
  int checked;
  int commutations;

  // idling control: gaps and stalls only while idle_on and not in the calm tail
  bit idle_on = 1'b1;
  bit calm = 1'b0;

  // back-emf waveform generator state
  int wave_pos = 0;
  int dwell_left = 0;
  int dwell_hi = 12;

  sensorless_bldc_six_step_commutator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  commutator_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_word_i      (in_word),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_word_i     (out_word),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .waiting_o      (waiting),
    .checked_o      (checked),
    .commutations_o (commutations)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && idle_on && !calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic sbldc_pkg::in_word_t pack_word(input sbldc_pkg::req_type_e kind,
                                                    input logic [2:0] abc,
                                                    input logic [1:0] buttons);
    sbldc_pkg::in_word_t w;
    w.req_type = kind;
    {w.cmp_a, w.cmp_b, w.cmp_c} = abc;
    {w.button_up, w.button_down} = buttons;
    return w;
  endfunction

  // comparator pattern {a, b, c} of a spinning rotor; each step flips exactly the
  // phase the commutator watches next: c rises, b falls, a rises, c falls, b rises, a falls
  function automatic logic [2:0] rotor_pattern(input int pos);
    logic [2:0] p;
    case (pos)
      0:       p = 3'b010;
      1:       p = 3'b011;
      2:       p = 3'b001;
      3:       p = 3'b101;
      4:       p = 3'b100;
      default: p = 3'b110;
    endcase
    return p;
  endfunction

  // mostly clean rotor waveform with random dwell, plus polls, glitches and noise
  function automatic sbldc_pkg::in_word_t motor_word();
    sbldc_pkg::in_word_t w;
    int roll;
    roll = $urandom_range(0, 99);
    w = sbldc_pkg::in_word_t'(6'($urandom_range(0, 63)));
    if (roll < 12) begin
      w.req_type = sbldc_pkg::REQ_BUTTON;
    end else if (roll < 20) begin
      w.req_type = sbldc_pkg::REQ_SAMPLE;
    end else begin
      if (dwell_left == 0) begin
        wave_pos = (wave_pos + 1) % 6;
        dwell_left = $urandom_range(1, dwell_hi);
      end
      dwell_left--;
      w.req_type = sbldc_pkg::REQ_SAMPLE;
      {w.cmp_a, w.cmp_b, w.cmp_c} = rotor_pattern(wave_pos);
      // occasional single-sample glitch on one comparator
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 2))
          0:       w.cmp_a = ~w.cmp_a;
          1:       w.cmp_b = ~w.cmp_b;
          default: w.cmp_c = ~w.cmp_c;
        endcase
      end
    end
    return w;
  endfunction

  // hand one word over, wait for acceptance, then maybe leave a gap
  task automatic send_word(input sbldc_pkg::in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and hold off until every predicted result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // all four registers, one write per cycle, while the block is idle
  task automatic load_settings(input logic [7:0] lo, input logic [7:0] hi,
                               input logic [3:0] qual, input logic [7:0] init);
    sbldc_pkg::cfg_idx_e regs [4];
    logic [7:0]          vals [4];
    regs = '{sbldc_pkg::CFG_MIN_DUTY, sbldc_pkg::CFG_MAX_DUTY,
             sbldc_pkg::CFG_QUALIFY, sbldc_pkg::CFG_INIT_DUTY};
    // upper nibble of the qualify write is junk the block must drop
    vals = '{lo, hi, {4'($urandom_range(0, 15)), qual}, init};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] lo, hi, init;
    logic [3:0] qual;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening words on reset settings: qualify 10, duty 100 within 50..255
    send_word(pack_word(sbldc_pkg::REQ_BUTTON, 3'b000, 2'b10));  // up
    send_word(pack_word(sbldc_pkg::REQ_BUTTON, 3'b111, 2'b01));  // down
    send_word(pack_word(sbldc_pkg::REQ_BUTTON, 3'b101, 2'b11));  // up then down
    send_word(pack_word(sbldc_pkg::REQ_BUTTON, 3'b010, 2'b00));  // plain poll
    // drives still off; a low on phase a is no edge
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b000, 2'b11));
    // phase a rises: either-edge arming starts qualifying, this sample not counted
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b100, 2'b00));
    // step 0 is even, so a low phase a counts
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b011, 2'b00));
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b001, 2'b00));
    // mismatch: neither counted nor clearing, and a further edge is ignored
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b100, 2'b00));
    // eight more matches reach ten and commutate to a high, b low, c rising
    for (int k = 0; k < 8; k++) begin
      send_word(pack_word(sbldc_pkg::REQ_SAMPLE, {1'b0, k[1:0]}, 2'b00));
    end
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b000, 2'b00));
    // c rises: armed edge on the new floating phase
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b001, 2'b00));
    // poll while qualifying leaves the comparator state alone
    send_word(pack_word(sbldc_pkg::REQ_BUTTON, 3'b000, 2'b11));
    send_word(pack_word(sbldc_pkg::REQ_SAMPLE, 3'b111, 2'b00));
    drain();

    for (int s = 1; s <= SETTINGS_RUN; s++) begin
      idle_on = 1'b1;
      case (s)
        1: begin
          // zero qualify count behaves as one
          lo = 8'd50; hi = 8'd255; qual = 4'd0; init = 8'd0;
        end
        2: begin
          // longest qualification, and a stretch with no idling at all
          lo = 8'd0; hi = 8'd255; qual = 4'd15; init = 8'd255;
          idle_on = 1'b0;
        end
        3: begin
          // crossed duty limits
          lo = 8'd200; hi = 8'd20; qual = 4'd1; init = 8'($urandom);
        end
        SWEEP_SETTING: begin
          lo = 8'd0; hi = 8'd255; qual = 4'($urandom_range(1, 15)); init = 8'($urandom);
        end
        5: begin
          lo = 8'($urandom_range(0, 127)); hi = 8'($urandom_range(128, 255));
          qual = 4'($urandom_range(1, 15)); init = 8'($urandom);
        end
        default: begin
          // last part runs without gaps or stalls
          lo = 8'($urandom); hi = 8'($urandom);
          qual = 4'($urandom_range(1, 15)); init = 8'($urandom);
          calm = 1'b1;
        end
      endcase
      load_settings(lo, hi, qual, init);
      dwell_hi = int'(qual) + 6;

      if (s == SWEEP_SETTING) begin
        // walk the duty down to zero, then up to full scale
        repeat (SWEEP_PRESSES) begin
          send_word(pack_word(sbldc_pkg::REQ_BUTTON, 3'($urandom), 2'b01));
        end
        repeat (SWEEP_PRESSES) begin
          send_word(pack_word(sbldc_pkg::REQ_BUTTON, 3'($urandom), 2'b10));
        end
      end else begin
        repeat (WORDS_PER_SETTING) send_word(motor_word());
      end
      // sender holds off until every result of this setting is back
      drain();
    end

    repeat (4) @(posedge clk);
    $display("run: %0d result words checked over %0d register settings, %0d commutations",
             checked, SETTINGS_RUN + 1, commutations);
    $display("run: qualify counts 0, 1, 15 and random, crossed limits, duty swept 0 to 255");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
